>>> rtl/mae_pkg.sv
// Package of the minimum arborescence engine: sizes, record types,
// register indexes, status codes and address helpers. No dependencies.
package mae_pkg;

  localparam int MAX_V = 64;
  localparam int MAX_E = 256;
  localparam int MAX_L = 10;
  localparam int WB    = 24;

  localparam int VW      = 7;
  localparam int VIW     = $clog2(MAX_V);
  localparam int EAW     = $clog2(MAX_E);
  localparam int ECW     = $clog2(MAX_E + 1);
  localparam int LW      = $clog2(MAX_L);
  localparam int EDGE_AW = LW + EAW;
  localparam int TREE_AW = LW + VIW;
  localparam int EDGE_DEPTH = MAX_L * (1 << EAW);
  localparam int TREE_DEPTH = MAX_L * (1 << VIW);
  localparam int PAW = 3;
  localparam int DW  = 32;

  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_ROOT   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EDGES = 2'd1;
  localparam logic [1:0] ST_DEEP  = 2'd2;

  typedef struct packed {
    logic [VW-1:0]  src;
    logic [VW-1:0]  dst;
    logic [WB-1:0]  w;
    logic [EAW-1:0] link;
  } arc_t;

  typedef struct packed {
    logic [VW-1:0]  par;
    logic           has;
    logic [WB-1:0]  w;
    logic [EAW-1:0] link;
  } pick_t;

  typedef struct packed {
    logic [VW-1:0] n;
    logic [VW-1:0] r;
  } cfg_t;

  function automatic logic [VIW-1:0] vidx(input logic [VW-1:0] v);
    logic [VW-1:0] d;
    d = v - VW'(1);
    return d[VIW-1:0];
  endfunction

  function automatic logic [EDGE_AW-1:0] edge_addr(input logic [LW-1:0] lvl,
                                                   input logic [ECW-1:0] idx);
    return {lvl, idx[EAW-1:0]};
  endfunction

  function automatic logic [TREE_AW-1:0] tree_addr(input logic [LW-1:0] lvl,
                                                   input logic [VW-1:0] v);
    return {lvl, vidx(v)};
  endfunction

endpackage

>>> rtl/mae_ifs.sv
// Handshake channels of the minimum arborescence engine: edge input and
// per-vertex result. Depends on mae_pkg.
interface mae_edge_if;
  logic                     valid;
  logic                     ready;
  logic [mae_pkg::VW-1:0]   edge_src;
  logic [mae_pkg::VW-1:0]   edge_dst;
  logic [mae_pkg::WB-1:0]   edge_weight;
  logic                     last_edge;
  modport source (output valid, edge_src, edge_dst, edge_weight, last_edge,
                  input ready);
  modport sink (input valid, edge_src, edge_dst, edge_weight, last_edge,
                output ready);
endinterface

interface mae_result_if;
  logic                     valid;
  logic                     ready;
  logic [mae_pkg::VW-1:0]   vertex_id;
  logic [mae_pkg::VW-1:0]   parent_vertex;
  logic                     has_parent;
  logic [mae_pkg::WB-1:0]   tree_weight;
  logic [1:0]               status;
  logic                     last_result;
  modport source (output valid, vertex_id, parent_vertex, has_parent, tree_weight,
                  status, last_result, input ready);
  modport sink (input valid, vertex_id, parent_vertex, has_parent, tree_weight,
                status, last_result, output ready);
endinterface

>>> rtl/mae_cfg_regs.sv
// APB register block: vertex count and root, with range clamping.
// Depends on mae_pkg.
module mae_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [mae_pkg::PAW-1:0] paddr,
  input  logic [mae_pkg::DW-1:0]  pwdata,
  output logic [mae_pkg::DW-1:0]  prdata,
  output logic                    pready,
  output mae_pkg::cfg_t           cfg
);
  import mae_pkg::*;

  logic [VW-1:0] vcount_r, vcount_nxt;
  logic [VW-1:0] root_r, root_nxt;
  logic [VW-1:0] n_c;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    vcount_nxt = vcount_r;
    root_nxt   = root_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_VCOUNT: vcount_nxt = pwdata[VW-1:0];
        REG_ROOT:   root_nxt   = pwdata[VW-1:0];
        default:    vcount_nxt = vcount_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VW'(1);
      root_r   <= VW'(1);
    end else begin
      vcount_r <= vcount_nxt;
      root_r   <= root_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_ROOT) ? DW'(root_r) : DW'(vcount_r);

  // Out-of-range counts and roots fall back to legal values.
  assign n_c   = (vcount_r == '0) ? VW'(1) :
                 (vcount_r > VW'(MAX_V)) ? VW'(MAX_V) : vcount_r;
  assign cfg.n = n_c;
  assign cfg.r = (root_r == '0 || root_r > n_c) ? VW'(1) : root_r;

endmodule

>>> rtl/min_arborescence_engine_core.sv
// Minimum arborescence engine top level: edge loading, Chu-Liu/Edmonds solve
// sequencer and result output. Depends on mae_pkg, mae_ifs, mae_cfg_regs.
// Loading takes one edge item per cycle. The item with last_edge set starts a
// solve that visits each stored edge and vertex on each contraction level,
// edge by edge and, in the cycle walks, step by step, bounded by the single
// read port of each store; then one result per vertex, each held until taken.
// Synchronous active-low reset clears the sequencer, edge count and flags.
module min_arborescence_engine_core (
  input  logic                    clk,
  input  logic                    rst_n,
  mae_edge_if.sink                in_ch,
  mae_result_if.source            out_ch,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [mae_pkg::PAW-1:0] paddr,
  input  logic [mae_pkg::DW-1:0]  pwdata,
  output logic [mae_pkg::DW-1:0]  prdata,
  output logic                    pready
);
  import mae_pkg::*;

  // Sequencer states.
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_FLT_RD   = 5'd1;
  localparam logic [4:0] S_FLT_CHK  = 5'd2;
  localparam logic [4:0] S_CLR      = 5'd3;
  localparam logic [4:0] S_PK_RD    = 5'd4;
  localparam logic [4:0] S_PK_TR    = 5'd5;
  localparam logic [4:0] S_PK_UP    = 5'd6;
  localparam logic [4:0] S_PK_ROOT  = 5'd7;
  localparam logic [4:0] S_LB_CLR   = 5'd8;
  localparam logic [4:0] S_WK_RD    = 5'd9;
  localparam logic [4:0] S_WK_CHK   = 5'd10;
  localparam logic [4:0] S_CY_LOOP  = 5'd11;
  localparam logic [4:0] S_CY_NEXT  = 5'd12;
  localparam logic [4:0] S_LB_END   = 5'd13;
  localparam logic [4:0] S_RN_RD    = 5'd14;
  localparam logic [4:0] S_RN_CHK   = 5'd15;
  localparam logic [4:0] S_CT_RD    = 5'd16;
  localparam logic [4:0] S_CT_SRC   = 5'd17;
  localparam logic [4:0] S_CT_DST   = 5'd18;
  localparam logic [4:0] S_CT_WR    = 5'd19;
  localparam logic [4:0] S_RT_RD    = 5'd20;
  localparam logic [4:0] S_RT_SET   = 5'd21;
  localparam logic [4:0] S_EX_START = 5'd22;
  localparam logic [4:0] S_EX_RD    = 5'd23;
  localparam logic [4:0] S_EX_EDGE  = 5'd24;
  localparam logic [4:0] S_EX_LO    = 5'd25;
  localparam logic [4:0] S_EX_WR    = 5'd26;
  localparam logic [4:0] S_OUT_RD   = 5'd27;
  localparam logic [4:0] S_OUT_LD   = 5'd28;
  localparam logic [4:0] S_OUT_WT   = 5'd29;

  cfg_t cfg;

  mae_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stores. Edges and picks are kept for every contraction level; the
  // label and walk-mark arrays are scratch for the cycle search.
  arc_t          edge_mem  [EDGE_DEPTH];
  pick_t         tree_mem  [TREE_DEPTH];
  logic [VW-1:0] label_mem [MAX_V];
  logic [VW-1:0] mark_mem  [MAX_V];

  logic               e_we, t_we, l_we, m_we;
  logic [EDGE_AW-1:0] e_wa, e_ra;
  logic [TREE_AW-1:0] t_wa, t_ra;
  logic [VIW-1:0]     l_wa, l_ra, m_wa, m_ra;
  arc_t               e_wd, e_rd_r;
  pick_t              t_wd, t_rd_r;
  logic [VW-1:0]      l_wd, l_rd_r, m_wd, m_rd_r;

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_wa] <= e_wd;
    end
    e_rd_r <= edge_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tree_mem[t_wa] <= t_wd;
    end
    t_rd_r <= tree_mem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      label_mem[l_wa] <= l_wd;
    end
    l_rd_r <= label_mem[l_ra];
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      mark_mem[m_wa] <= m_wd;
    end
    m_rd_r <= mark_mem[m_ra];
  end

  // Sequencer registers.
  logic [4:0]     state_r, state_nxt;
  logic [ECW-1:0] cnt0_r, cnt0_nxt;       // edges loaded at level zero
  logic           ovf_r, ovf_nxt;         // an edge was dropped while loading
  logic           deep_r, deep_nxt;       // contraction hit the level limit
  logic [LW-1:0]  lvl_r, lvl_nxt;
  logic [VW-1:0]  root_r, root_nxt;
  logic [ECW-1:0] ec_r [MAX_L];
  logic [ECW-1:0] ec_nxt [MAX_L];
  logic [VW-1:0]  lv_r [MAX_L];
  logic [VW-1:0]  lv_nxt [MAX_L];
  logic [ECW-1:0] e_r, e_nxt;             // edge being visited
  logic [ECW-1:0] k_r, k_nxt;             // edges written so far
  logic [VW-1:0]  u_r, u_nxt;
  logic [VW-1:0]  v_r, v_nxt;
  logic [VW-1:0]  x_r, x_nxt;
  logic [VW-1:0]  c_r, c_nxt;             // cycles found, then label count
  logic [VW-1:0]  ls_r, ls_nxt;           // label of the held edge's source
  arc_t           ed_r, ed_nxt;
  pick_t          hp_r, hp_nxt;

  // Result register.
  logic           ov_r, ov_nxt;
  logic [VW-1:0]  o_vid_r, o_vid_nxt;
  logic [VW-1:0]  o_par_r, o_par_nxt;
  logic           o_has_r, o_has_nxt;
  logic [WB-1:0]  o_w_r, o_w_nxt;
  logic [1:0]     o_st_r, o_st_nxt;
  logic           o_last_r, o_last_nxt;

  logic [VW-1:0]  nv;
  logic [ECW-1:0] ec_cur;
  logic [LW-1:0]  lvl_up, lvl_dn;
  logic           in_acc, out_acc;
  logic           flt_ok, walk_go;

  assign nv      = lv_r[lvl_r];
  assign ec_cur  = ec_r[lvl_r];
  assign lvl_up  = lvl_r + LW'(1);
  assign lvl_dn  = lvl_r - LW'(1);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // An edge survives the solve only if both ends lie in range and differ.
  assign flt_ok = (e_rd_r.src != '0) && (e_rd_r.dst != '0) &&
                  (e_rd_r.src <= cfg.n) && (e_rd_r.dst <= cfg.n) &&
                  (e_rd_r.src != e_rd_r.dst);

  // The walk follows picks until it meets the root, a labeled cycle, its own
  // trail, or a vertex without an incoming edge.
  assign walk_go = (v_r != root_r) && (l_rd_r == '0) && (m_rd_r != u_r) && t_rd_r.has;

  always_comb begin
    state_nxt = state_r;
    cnt0_nxt  = cnt0_r;
    ovf_nxt   = ovf_r;
    deep_nxt  = deep_r;
    lvl_nxt   = lvl_r;
    root_nxt  = root_r;
    ec_nxt    = ec_r;
    lv_nxt    = lv_r;
    e_nxt     = e_r;
    k_nxt     = k_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    x_nxt     = x_r;
    c_nxt     = c_r;
    ls_nxt    = ls_r;
    ed_nxt    = ed_r;
    hp_nxt    = hp_r;
    ov_nxt     = ov_r;
    o_vid_nxt  = o_vid_r;
    o_par_nxt  = o_par_r;
    o_has_nxt  = o_has_r;
    o_w_nxt    = o_w_r;
    o_st_nxt   = o_st_r;
    o_last_nxt = o_last_r;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
    m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt0_r < ECW'(MAX_E)) begin
            e_we     = 1'b1;
            e_wa     = edge_addr('0, cnt0_r);
            e_wd     = '{src: in_ch.edge_src, dst: in_ch.edge_dst,
                         w: in_ch.edge_weight, link: '0};
            cnt0_nxt = cnt0_r + ECW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_edge) begin
            e_nxt     = '0;
            k_nxt     = '0;
            deep_nxt  = 1'b0;
            state_nxt = S_FLT_RD;
          end
        end
      end

      // Compact level zero down to the edges that can take part.
      S_FLT_RD: begin
        if (e_r == cnt0_r) begin
          ec_nxt[0] = k_r;
          lv_nxt[0] = cfg.n;
          lvl_nxt   = '0;
          root_nxt  = cfg.r;
          u_nxt     = VW'(1);
          state_nxt = S_CLR;
        end else begin
          e_ra      = edge_addr('0, e_r);
          state_nxt = S_FLT_CHK;
        end
      end
      S_FLT_CHK: begin
        if (flt_ok) begin
          e_we  = 1'b1;
          e_wa  = edge_addr('0, k_r);
          e_wd  = e_rd_r;
          k_nxt = k_r + ECW'(1);
        end
        e_nxt     = e_r + ECW'(1);
        state_nxt = S_FLT_RD;
      end

      // Cheapest incoming edge per vertex; the first of equal weights wins.
      S_CLR: begin
        t_we = 1'b1;
        t_wa = tree_addr(lvl_r, u_r);
        t_wd = '0;
        if (u_r == nv) begin
          e_nxt     = '0;
          state_nxt = S_PK_RD;
        end else begin
          u_nxt = u_r + VW'(1);
        end
      end
      S_PK_RD: begin
        if (e_r == ec_cur) begin
          state_nxt = S_PK_ROOT;
        end else begin
          e_ra      = edge_addr(lvl_r, e_r);
          state_nxt = S_PK_TR;
        end
      end
      S_PK_TR: begin
        ed_nxt    = e_rd_r;
        t_ra      = tree_addr(lvl_r, e_rd_r.dst);
        state_nxt = S_PK_UP;
      end
      S_PK_UP: begin
        if (!t_rd_r.has || (ed_r.w < t_rd_r.w)) begin
          t_we = 1'b1;
          t_wa = tree_addr(lvl_r, ed_r.dst);
          t_wd = '{par: ed_r.src, has: 1'b1, w: ed_r.w, link: ed_r.link};
        end
        e_nxt     = e_r + ECW'(1);
        state_nxt = S_PK_RD;
      end
      S_PK_ROOT: begin
        t_we      = 1'b1;
        t_wa      = tree_addr(lvl_r, root_r);
        t_wd      = '0;
        u_nxt     = VW'(1);
        state_nxt = S_LB_CLR;
      end

      // Cycle search over the picks.
      S_LB_CLR: begin
        l_we = 1'b1;
        l_wa = vidx(u_r);
        l_wd = '0;
        m_we = 1'b1;
        m_wa = vidx(u_r);
        m_wd = '0;
        if (u_r == nv) begin
          u_nxt     = VW'(1);
          v_nxt     = VW'(1);
          c_nxt     = '0;
          state_nxt = S_WK_RD;
        end else begin
          u_nxt = u_r + VW'(1);
        end
      end
      S_WK_RD: begin
        l_ra      = vidx(v_r);
        m_ra      = vidx(v_r);
        t_ra      = tree_addr(lvl_r, v_r);
        state_nxt = S_WK_CHK;
      end
      S_WK_CHK: begin
        if (walk_go) begin
          m_we      = 1'b1;
          m_wa      = vidx(v_r);
          m_wd      = u_r;
          v_nxt     = t_rd_r.par;
          state_nxt = S_WK_RD;
        end else if (m_rd_r == u_r) begin
          c_nxt     = c_r + VW'(1);
          x_nxt     = t_rd_r.par;
          state_nxt = S_CY_LOOP;
        end else if (u_r == nv) begin
          state_nxt = S_LB_END;
        end else begin
          u_nxt     = u_r + VW'(1);
          v_nxt     = u_r + VW'(1);
          state_nxt = S_WK_RD;
        end
      end
      S_CY_LOOP: begin
        l_we = 1'b1;
        l_wd = c_r;
        if (x_r == v_r) begin
          l_wa = vidx(v_r);
          if (u_r == nv) begin
            state_nxt = S_LB_END;
          end else begin
            u_nxt     = u_r + VW'(1);
            v_nxt     = u_r + VW'(1);
            state_nxt = S_WK_RD;
          end
        end else begin
          l_wa      = vidx(x_r);
          t_ra      = tree_addr(lvl_r, x_r);
          state_nxt = S_CY_NEXT;
        end
      end
      S_CY_NEXT: begin
        x_nxt     = t_rd_r.par;
        state_nxt = S_CY_LOOP;
      end
      S_LB_END: begin
        if (c_r == '0) begin
          state_nxt = S_EX_START;
        end else if (32'(lvl_r) + 32'd1 >= 32'(MAX_L)) begin
          deep_nxt  = 1'b1;
          state_nxt = S_EX_START;
        end else begin
          u_nxt     = VW'(1);
          state_nxt = S_RN_RD;
        end
      end

      // Vertices outside any cycle get labels after the cycle labels.
      S_RN_RD: begin
        l_ra      = vidx(u_r);
        state_nxt = S_RN_CHK;
      end
      S_RN_CHK: begin
        if (l_rd_r == '0) begin
          l_we  = 1'b1;
          l_wa  = vidx(u_r);
          l_wd  = c_r + VW'(1);
          c_nxt = c_r + VW'(1);
        end
        if (u_r == nv) begin
          lv_nxt[lvl_up] = c_nxt;
          e_nxt          = '0;
          k_nxt          = '0;
          state_nxt      = S_CT_RD;
        end else begin
          u_nxt     = u_r + VW'(1);
          state_nxt = S_RN_RD;
        end
      end

      // Contraction: edges between different labels move to the next level
      // with their weight reduced by the pick weight of their head.
      S_CT_RD: begin
        if (e_r == ec_cur) begin
          ec_nxt[lvl_up] = k_r;
          state_nxt      = S_RT_RD;
        end else begin
          e_ra      = edge_addr(lvl_r, e_r);
          state_nxt = S_CT_SRC;
        end
      end
      S_CT_SRC: begin
        ed_nxt    = e_rd_r;
        l_ra      = vidx(e_rd_r.src);
        state_nxt = S_CT_DST;
      end
      S_CT_DST: begin
        ls_nxt    = l_rd_r;
        l_ra      = vidx(ed_r.dst);
        t_ra      = tree_addr(lvl_r, ed_r.dst);
        state_nxt = S_CT_WR;
      end
      S_CT_WR: begin
        if (ls_r != l_rd_r) begin
          e_we  = 1'b1;
          e_wa  = edge_addr(lvl_up, k_r);
          e_wd  = '{src: ls_r, dst: l_rd_r, w: ed_r.w - t_rd_r.w,
                    link: e_r[EAW-1:0]};
          k_nxt = k_r + ECW'(1);
        end
        e_nxt     = e_r + ECW'(1);
        state_nxt = S_CT_RD;
      end
      S_RT_RD: begin
        l_ra      = vidx(root_r);
        state_nxt = S_RT_SET;
      end
      S_RT_SET: begin
        root_nxt  = l_rd_r;
        lvl_nxt   = lvl_up;
        u_nxt     = VW'(1);
        state_nxt = S_CLR;
      end

      // Expansion: each pick of a contracted vertex replaces the pick of the
      // real head of its original edge one level down.
      S_EX_START: begin
        if (lvl_r == '0) begin
          v_nxt     = VW'(1);
          state_nxt = S_OUT_RD;
        end else begin
          u_nxt     = VW'(1);
          state_nxt = S_EX_RD;
        end
      end
      S_EX_RD: begin
        t_ra      = tree_addr(lvl_r, u_r);
        state_nxt = S_EX_EDGE;
      end
      S_EX_EDGE: begin
        hp_nxt = t_rd_r;
        if (t_rd_r.has) begin
          e_ra      = edge_addr(lvl_dn, ECW'(t_rd_r.link));
          state_nxt = S_EX_LO;
        end else if (u_r == nv) begin
          lvl_nxt   = lvl_dn;
          state_nxt = S_EX_START;
        end else begin
          u_nxt     = u_r + VW'(1);
          state_nxt = S_EX_RD;
        end
      end
      S_EX_LO: begin
        ed_nxt    = e_rd_r;
        t_ra      = tree_addr(lvl_dn, e_rd_r.dst);
        state_nxt = S_EX_WR;
      end
      S_EX_WR: begin
        t_we = 1'b1;
        t_wa = tree_addr(lvl_dn, ed_r.dst);
        t_wd = '{par: ed_r.src, has: 1'b1, w: t_rd_r.w + hp_r.w, link: ed_r.link};
        if (u_r == nv) begin
          lvl_nxt   = lvl_dn;
          state_nxt = S_EX_START;
        end else begin
          u_nxt     = u_r + VW'(1);
          state_nxt = S_EX_RD;
        end
      end

      // One result item per vertex in ascending order.
      S_OUT_RD: begin
        t_ra      = tree_addr('0, v_r);
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        ov_nxt     = 1'b1;
        o_vid_nxt  = v_r;
        o_has_nxt  = t_rd_r.has;
        o_par_nxt  = t_rd_r.has ? t_rd_r.par : '0;
        o_w_nxt    = t_rd_r.has ? t_rd_r.w : '0;
        o_st_nxt   = ovf_r ? ST_EDGES : (deep_r ? ST_DEEP : ST_OK);
        o_last_nxt = (v_r == cfg.n);
        state_nxt  = S_OUT_WT;
      end
      S_OUT_WT: begin
        if (out_acc) begin
          ov_nxt = 1'b0;
          if (v_r == cfg.n) begin
            cnt0_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            v_nxt     = v_r + VW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt0_r  <= '0;
      ovf_r   <= 1'b0;
      deep_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt0_r  <= cnt0_nxt;
      ovf_r   <= ovf_nxt;
      deep_r  <= deep_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r    <= lvl_nxt;
    root_r   <= root_nxt;
    ec_r     <= ec_nxt;
    lv_r     <= lv_nxt;
    e_r      <= e_nxt;
    k_r      <= k_nxt;
    u_r      <= u_nxt;
    v_r      <= v_nxt;
    x_r      <= x_nxt;
    c_r      <= c_nxt;
    ls_r     <= ls_nxt;
    ed_r     <= ed_nxt;
    hp_r     <= hp_nxt;
    o_vid_r  <= o_vid_nxt;
    o_par_r  <= o_par_nxt;
    o_has_r  <= o_has_nxt;
    o_w_r    <= o_w_nxt;
    o_st_r   <= o_st_nxt;
    o_last_r <= o_last_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.vertex_id     = o_vid_r;
  assign out_ch.parent_vertex = o_par_r;
  assign out_ch.has_parent    = o_has_r;
  assign out_ch.tree_weight   = o_w_r;
  assign out_ch.status        = o_st_r;
  assign out_ch.last_result   = o_last_r;

  // Loading and result delivery never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("edge input open while a result is pending");

  // The level-zero edge count never passes the store size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt0_r <= ECW'(MAX_E))
    else $error("edge count beyond store size");

  // Every result names a vertex of the graph.
  a_vid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.vertex_id != '0) && (out_ch.vertex_id <= cfg.n))
    else $error("result vertex out of range");

  // Taking the final result reopens the edge input.
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last_result) |=> in_ch.ready)
    else $error("engine did not return to loading after the last result");

endmodule
